// File: sv/rltw_pkg.sv
// ============================================================================
// rltw_pkg: shared types and constants for the ring log time window query
// Record layout, opcodes, status codes, store request bundle, result beat and ring geometry.
// ============================================================================
package rltw_pkg;

  // Ring geometry
  localparam int LOG_DEPTH = 64;
  localparam int ADDR_W    = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;

  // Field widths
  localparam int OP_W     = 2;
  localparam int SLOT_W   = 6;
  localparam int TIME_W   = 32;
  localparam int SECTOR_W = 8;
  localparam int TEMP_W   = 16;
  localparam int STATUS_W = 3;

  // Opcodes
  localparam logic [OP_W-1:0] OP_WRITE    = 2'd0;
  localparam logic [OP_W-1:0] OP_Q_NEWEST = 2'd1;
  localparam logic [OP_W-1:0] OP_Q_WINDOW = 2'd2;
  localparam logic [OP_W-1:0] OP_NEXT     = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_RECORD   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_WRITTEN  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_START = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_END   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NO_MATCH = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NEXT     = 3'd5;

  // One stored record
  typedef struct packed {
    logic        [TIME_W-1:0]   rtime;
    logic        [SECTOR_W-1:0] sector;
    logic signed [TEMP_W-1:0]   temp;
  } rec_t;

  // Request to the record store: one port, write or read
  typedef struct packed {
    logic              wr;
    logic              rd;
    logic [ADDR_W-1:0] addr;
  } mem_req_t;

  // One result beat
  typedef struct packed {
    logic        [STATUS_W-1:0] status;
    logic        [TIME_W-1:0]   out_time;
    logic        [SECTOR_W-1:0] out_sector;
    logic signed [TEMP_W-1:0]   out_temp;
    logic        [SLOT_W-1:0]   next_slot;
    logic                       last;
  } out_beat_t;

endpackage

// File: sv/rltw_in_if.sv
// ============================================================================
// rltw_in_if: input channel of the ring log time window query
// Valid/ready channel carrying one command beat.
// ============================================================================
interface rltw_in_if;
  logic                                 valid;
  logic                                 ready;
  logic        [rltw_pkg::OP_W-1:0]     opcode;
  logic        [rltw_pkg::SLOT_W-1:0]   slot;
  logic        [rltw_pkg::TIME_W-1:0]   rec_time;
  logic        [rltw_pkg::SECTOR_W-1:0] rec_sector;
  logic signed [rltw_pkg::TEMP_W-1:0]   rec_temp;
  logic        [rltw_pkg::TIME_W-1:0]   start_time;
  logic        [rltw_pkg::TIME_W-1:0]   end_time;
  logic        [rltw_pkg::SECTOR_W-1:0] sector_filter;

  modport source (
    output valid, opcode, slot, rec_time, rec_sector, rec_temp,
           start_time, end_time, sector_filter,
    input  ready
  );
  modport sink (
    input  valid, opcode, slot, rec_time, rec_sector, rec_temp,
           start_time, end_time, sector_filter,
    output ready
  );
endinterface

// File: sv/rltw_out_if.sv
// ============================================================================
// rltw_out_if: result channel of the ring log time window query
// Valid/ready channel carrying one result beat.
// ============================================================================
interface rltw_out_if;
  logic                                 valid;
  logic                                 ready;
  logic        [rltw_pkg::STATUS_W-1:0] status;
  logic        [rltw_pkg::TIME_W-1:0]   out_time;
  logic        [rltw_pkg::SECTOR_W-1:0] out_sector;
  logic signed [rltw_pkg::TEMP_W-1:0]   out_temp;
  logic        [rltw_pkg::SLOT_W-1:0]   next_slot;
  logic                                 last;

  modport source (
    output valid, status, out_time, out_sector, out_temp, next_slot, last,
    input  ready
  );
  modport sink (
    input  valid, status, out_time, out_sector, out_temp, next_slot, last,
    output ready
  );
endinterface

// File: sv/ring_log_time_window_query.sv
// ============================================================================
// ring_log_time_window_query: ring of timestamped records with window query
// Stores (time, sector, temperature) records and lists a time window of them.
// ============================================================================
// Usage:
//   in_ch  : command beats (valid/ready). Opcode 0 writes a slot, opcodes 1
//            and 2 list records between two bounds, opcode 3 reports the
//            next slot to write. A command is taken only while the sequencer
//            is idle; ready drops for the whole of its work.
//   out_ch : result beats (valid/ready) from an output register; last marks
//            the final beat of a command.
// Sequence (LOG_DEPTH = N slots, one store read port):
//   write      : S_WRAP folds an out-of-range slot number, then S_WRITE stores.
//   next slot  : one pipelined pass over the store.
//   query      : one pipelined pass over the store for the bounds, then a walk
//                that reads, then evaluates each slot, then flushes the final beat.
//   The single store port shapes this: the scan reads one record per
//   cycle, the walk reads a slot and evaluates it before the next read.
// Reset: synchronous, active low; all store entries read as zero records
//   at once (per-entry valid bits), no clearing pass.
// Stall: while out_ch is stalled the walk holds on a matching slot while a held
//   record waits to go out, and resumes as soon as the output register frees.
// ============================================================================
module ring_log_time_window_query (
  input logic       clk,
  input logic       rst_n,
  rltw_in_if.sink   in_ch,
  rltw_out_if.source out_ch
);

  localparam int AW = rltw_pkg::ADDR_W;
  localparam logic [AW-1:0] LAST_IDX = AW'(rltw_pkg::LOG_DEPTH - 1);

  // Sequencer codes
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_WRAP   = 3'd1;
  localparam logic [2:0] S_WRITE  = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;
  localparam logic [2:0] S_WRD    = 3'd5;
  localparam logic [2:0] S_WEV    = 3'd6;
  localparam logic [2:0] S_FIN    = 3'd7;

  // Control registers
  logic [2:0]    state_r, state_nxt;
  logic          iss_r, iss_nxt;
  logic          dv_r, dv_nxt;
  logic          have_lo_r, have_lo_nxt;
  logic          have_hi_r, have_hi_nxt;
  logic          pend_r, pend_nxt;
  logic          out_vld_r, out_vld_nxt;

  // Working registers
  logic [rltw_pkg::OP_W-1:0]     op_r, op_nxt;
  logic [rltw_pkg::SLOT_W-1:0]   wrap_r, wrap_nxt;
  rltw_pkg::rec_t                rec_r, rec_nxt;
  logic [rltw_pkg::TIME_W-1:0]   start_r, start_nxt;
  logic [rltw_pkg::TIME_W-1:0]   end_r, end_nxt;
  logic [rltw_pkg::SECTOR_W-1:0] filt_r, filt_nxt;
  logic [AW-1:0]                 idx_r, idx_nxt;
  logic [AW-1:0]                 didx_r, didx_nxt;
  logic [rltw_pkg::TIME_W-1:0]   lo_r, lo_nxt;
  logic [rltw_pkg::TIME_W-1:0]   hi_r, hi_nxt;
  logic [AW-1:0]                 first_r, first_nxt;
  logic [AW-1:0]                 lasts_r, lasts_nxt;
  rltw_pkg::rec_t                pend_rec_r, pend_rec_nxt;
  rltw_pkg::out_beat_t           out_r, out_nxt;

  // Store interface
  rltw_pkg::mem_req_t req;
  rltw_pkg::rec_t     rd_data;

  // Shared compare unit and helpers
  logic          in_acc;
  logic          can_push;
  logic          push;
  logic          ge_start, lt_lo, le_end, gt_hi, ge_hi;
  logic          take_lo, take_hi;
  logic          match;
  logic [AW-1:0] idx_inc;
  logic [AW-1:0] nxt_idx;
  rltw_pkg::out_beat_t push_beat;

  rltw_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .wr_data (rec_r),
    .rd_data (rd_data)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign can_push    = !out_vld_r || out_ch.ready;

  // Compare the record on the read port against the running bounds
  assign ge_start = rd_data.rtime >= start_r;
  assign lt_lo    = rd_data.rtime <  lo_r;
  assign le_end   = rd_data.rtime <= end_r;
  assign gt_hi    = rd_data.rtime >  hi_r;
  assign ge_hi    = rd_data.rtime >= hi_r;
  assign take_lo  = ge_start && (!have_lo_r || lt_lo);

  always_comb begin
    case (op_r)
      rltw_pkg::OP_NEXT:     take_hi = !have_hi_r || ge_hi;
      rltw_pkg::OP_Q_WINDOW: take_hi = le_end && (!have_hi_r || gt_hi);
      default:               take_hi = !have_hi_r || gt_hi;
    endcase
  end

  assign match   = (filt_r == '0) || (rd_data.sector == filt_r);
  assign idx_inc = (idx_r == LAST_IDX) ? '0 : idx_r + AW'(1);
  assign nxt_idx = (hi_r == '0) ? '0 : ((lasts_r == LAST_IDX) ? '0 : lasts_r + AW'(1));

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    iss_nxt      = iss_r;
    dv_nxt       = 1'b0;
    have_lo_nxt  = have_lo_r;
    have_hi_nxt  = have_hi_r;
    pend_nxt     = pend_r;
    op_nxt       = op_r;
    wrap_nxt     = wrap_r;
    rec_nxt      = rec_r;
    start_nxt    = start_r;
    end_nxt      = end_r;
    filt_nxt     = filt_r;
    idx_nxt      = idx_r;
    didx_nxt     = idx_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    first_nxt    = first_r;
    lasts_nxt    = lasts_r;
    pend_rec_nxt = pend_rec_r;
    req          = '0;
    push         = 1'b0;
    push_beat    = '0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt       = in_ch.opcode;
          wrap_nxt     = in_ch.slot;
          rec_nxt      = '{rtime: in_ch.rec_time, sector: in_ch.rec_sector,
                           temp: in_ch.rec_temp};
          start_nxt    = in_ch.start_time;
          end_nxt      = in_ch.end_time;
          filt_nxt     = in_ch.sector_filter;
          idx_nxt      = '0;
          iss_nxt      = 1'b1;
          have_lo_nxt  = 1'b0;
          have_hi_nxt  = 1'b0;
          state_nxt    = (in_ch.opcode == rltw_pkg::OP_WRITE) ? S_WRAP : S_SCAN;
        end
      end

      // Fold an out-of-range slot number back into the ring
      S_WRAP: begin
        if (32'(wrap_r) >= 32'(rltw_pkg::LOG_DEPTH)) begin
          wrap_nxt = wrap_r - rltw_pkg::SLOT_W'(rltw_pkg::LOG_DEPTH);
        end else begin
          state_nxt = S_WRITE;
        end
      end

      // Store the record and acknowledge in the same cycle
      S_WRITE: begin
        if (can_push) begin
          req.wr           = 1'b1;
          req.addr         = AW'(32'(wrap_r));
          push             = 1'b1;
          push_beat.status = rltw_pkg::ST_WRITTEN;
          push_beat.last   = 1'b1;
          state_nxt        = S_IDLE;
        end
      end

      // Pipelined pass over every slot: issue a read, evaluate the one before
      S_SCAN: begin
        if (iss_r) begin
          req.rd  = 1'b1;
          req.addr = idx_r;
          dv_nxt  = 1'b1;
          idx_nxt = idx_inc;
          if (idx_r == LAST_IDX) begin
            iss_nxt = 1'b0;
          end
        end
        if (dv_r) begin
          if (take_lo) begin
            lo_nxt      = rd_data.rtime;
            first_nxt   = didx_r;
            have_lo_nxt = 1'b1;
          end
          if (take_hi) begin
            hi_nxt      = rd_data.rtime;
            lasts_nxt   = didx_r;
            have_hi_nxt = 1'b1;
          end
          if (didx_r == LAST_IDX) begin
            state_nxt = S_DECIDE;
          end
        end
      end

      // Report the next slot or an error, or start the walk
      S_DECIDE: begin
        if (op_r == rltw_pkg::OP_NEXT) begin
          if (can_push) begin
            push                = 1'b1;
            push_beat.status    = rltw_pkg::ST_NEXT;
            push_beat.next_slot = rltw_pkg::SLOT_W'(32'(nxt_idx));
            push_beat.last      = 1'b1;
            state_nxt           = S_IDLE;
          end
        end else if (!have_lo_r || !have_hi_r) begin
          if (can_push) begin
            push             = 1'b1;
            push_beat.status = !have_lo_r ? rltw_pkg::ST_NO_START : rltw_pkg::ST_NO_END;
            push_beat.last   = 1'b1;
            state_nxt        = S_IDLE;
          end
        end else begin
          idx_nxt   = first_r;
          pend_nxt  = 1'b0;
          state_nxt = S_WRD;
        end
      end

      S_WRD: begin
        req.rd    = 1'b1;
        req.addr  = idx_r;
        state_nxt = S_WEV;
      end

      // Hold one matching record back so the final one can carry last
      S_WEV: begin
        if (!(match && pend_r && !can_push)) begin
          if (match) begin
            if (pend_r) begin
              push                 = 1'b1;
              push_beat.status     = rltw_pkg::ST_RECORD;
              push_beat.out_time   = pend_rec_r.rtime;
              push_beat.out_sector = pend_rec_r.sector;
              push_beat.out_temp   = pend_rec_r.temp;
            end
            pend_rec_nxt = rd_data;
            pend_nxt     = 1'b1;
          end
          if (idx_r == lasts_r) begin
            state_nxt = S_FIN;
          end else begin
            idx_nxt   = idx_inc;
            state_nxt = S_WRD;
          end
        end
      end

      // Flush the held record, or report an empty listing
      S_FIN: begin
        if (can_push) begin
          push           = 1'b1;
          push_beat.last = 1'b1;
          if (pend_r) begin
            push_beat.status     = rltw_pkg::ST_RECORD;
            push_beat.out_time   = pend_rec_r.rtime;
            push_beat.out_sector = pend_rec_r.sector;
            push_beat.out_temp   = pend_rec_r.temp;
          end else begin
            push_beat.status = rltw_pkg::ST_NO_MATCH;
          end
          pend_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register: load on push, drop on a taken beat
  always_comb begin
    out_vld_nxt = out_vld_r;
    out_nxt     = out_r;
    if (out_vld_r && out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
    if (push) begin
      out_vld_nxt = 1'b1;
      out_nxt     = push_beat;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      iss_r     <= 1'b0;
      dv_r      <= 1'b0;
      have_lo_r <= 1'b0;
      have_hi_r <= 1'b0;
      pend_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      iss_r     <= iss_nxt;
      dv_r      <= dv_nxt;
      have_lo_r <= have_lo_nxt;
      have_hi_r <= have_hi_nxt;
      pend_r    <= pend_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    wrap_r     <= wrap_nxt;
    rec_r      <= rec_nxt;
    start_r    <= start_nxt;
    end_r      <= end_nxt;
    filt_r     <= filt_nxt;
    idx_r      <= idx_nxt;
    didx_r     <= didx_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    first_r    <= first_nxt;
    lasts_r    <= lasts_nxt;
    pend_rec_r <= pend_rec_nxt;
    out_r      <= out_nxt;
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.status     = out_r.status;
  assign out_ch.out_time   = out_r.out_time;
  assign out_ch.out_sector = out_r.out_sector;
  assign out_ch.out_temp   = out_r.out_temp;
  assign out_ch.next_slot  = out_r.next_slot;
  assign out_ch.last       = out_r.last;

  // Checks on the sequencer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready)
    else $error("input taken again right after an accepted beat");

  a_scan_covers_ring: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE && $past(state_r) == S_SCAN) |-> $past(didx_r) == LAST_IDX)
    else $error("bound scan ended before the last slot");

  a_eval_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WEV) |-> ($past(state_r) == S_WRD || $past(state_r) == S_WEV))
    else $error("walk evaluated a slot without reading it");

  a_non_last_is_record: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !push_beat.last) |-> push_beat.status == rltw_pkg::ST_RECORD)
    else $error("non-final result beat is not a record");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_ch.ready) |=> !$changed(out_r) || !$past(out_vld_r))
    else $error("result overwritten while stalled");

endmodule

// File: sv/rltw_store.sv
// ============================================================================
// rltw_store: record store of the ring log
// Single-port record memory with registered read data and per-entry valid
// bits; an entry never written since reset reads as an all-zero record.
// ============================================================================
module rltw_store (
  input  logic               clk,
  input  logic               rst_n,
  input  rltw_pkg::mem_req_t req,
  input  rltw_pkg::rec_t     wr_data,
  output rltw_pkg::rec_t     rd_data
);

  rltw_pkg::rec_t                  mem [rltw_pkg::LOG_DEPTH];
  logic [rltw_pkg::LOG_DEPTH-1:0]  vld_r;
  rltw_pkg::rec_t                  rd_data_r;
  logic                            rd_vld_r;

  // Write the record array and register the read port
  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.addr] <= wr_data;
    end
    if (req.rd) begin
      rd_data_r <= mem[req.addr];
    end
  end

  // Track written entries; reset clears them all at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.wr) begin
        vld_r[req.addr] <= 1'b1;
      end
      if (req.rd) begin
        rd_vld_r <= vld_r[req.addr];
      end
    end
  end

  // Substitute the reset value for entries never written
  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule
